/* src/fahq_pkg.sv */
// ============================================================================
// fahq_pkg
// Shared types, field widths and codes of the four-ary min-heap queue.
// ============================================================================
package fahq_pkg;

    localparam int DEF_HEAP_DEPTH = 1024;
    localparam int DEF_ARITY      = 4;

    localparam int KEY_W    = 16;
    localparam int TAG_W    = 16;
    localparam int ENTRY_W  = KEY_W + TAG_W;
    localparam int STATUS_W = 2;

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef logic [ENTRY_W-1:0] t_entry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_PAR,
        S_UP_RD,
        S_UP_CMP,
        S_POP_ROOT,
        S_POP_LAST,
        S_DN_CHILD,
        S_DN_CMP,
        S_DN_DEC,
        S_DONE
    } t_state;

    function automatic logic [KEY_W-1:0] key_of(input t_entry e);
        key_of = e[ENTRY_W-1 -: KEY_W];
    endfunction

endpackage

/* src/fahq_ram.sv */
// ============================================================================
// fahq_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module fahq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/four_ary_min_heap_queue.sv */
// ============================================================================
// four_ary_min_heap_queue
// d-ary min-heap priority queue held in one RAM, sifted by a small sequencer.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one word: i_mode selects
//   push (0) or pop (1); push carries i_priority_key and i_entry_tag.
//   Output channel (o_out_valid / i_out_stall) returns one word per input:
//   popped key and tag (zero otherwise), status (0 done, 1 full, 2 empty)
//   and occupancy after the operation.
//   One operation is in flight at a time; o_in_stall stays high from accept
//   until its result is loaded into the output register.
//   The sift runs on the single RAM port pair. A push climbs one level per
//   round of S_UP_PAR, S_UP_RD and S_UP_CMP; a pop reads the root and the
//   last entry, then descends one level per round of S_DN_CHILD, one
//   S_DN_CMP per child read and S_DN_DEC. Refused operations go straight
//   to S_DONE.
//   A waiting result does not block the next accept; a finished operation
//   holds in its last step while the output register is stalled.
//   Reset empties the heap; RAM contents are not cleared.
// ============================================================================
module four_ary_min_heap_queue #(
    parameter int HEAP_DEPTH = fahq_pkg::DEF_HEAP_DEPTH,
    parameter int ARITY      = fahq_pkg::DEF_ARITY
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_mode,
    input  logic [fahq_pkg::KEY_W-1:0]        i_priority_key,
    input  logic [fahq_pkg::TAG_W-1:0]        i_entry_tag,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [fahq_pkg::KEY_W-1:0]        o_out_key,
    output logic [fahq_pkg::TAG_W-1:0]        o_out_tag,
    output logic [fahq_pkg::STATUS_W-1:0]     o_status,
    output logic [$clog2(HEAP_DEPTH+1)-1:0]   o_occupancy
);

    import fahq_pkg::*;

    localparam int IDX_W  = $clog2(HEAP_DEPTH);
    localparam int CNT_W  = $clog2(HEAP_DEPTH + 1);
    localparam int J_W    = $clog2(ARITY);
    localparam int CH_W   = IDX_W + J_W + 1;
    localparam int DIV_S  = IDX_W + J_W;
    localparam int DIV_M  = ((1 << DIV_S) + ARITY - 1) / ARITY;
    localparam int PROD_W = DIV_S + IDX_W;

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(HEAP_DEPTH);
    localparam logic [J_W-1:0]   LAST_J   = J_W'(ARITY - 1);

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [IDX_W-1:0]      r_pos, n_pos;
    logic [IDX_W-1:0]      r_parent, n_parent;
    logic [CH_W-1:0]       r_child, n_child;
    logic [J_W-1:0]        r_j, n_j;
    t_entry                r_move, n_move;
    t_entry                r_best, n_best;
    logic [IDX_W-1:0]      r_best_pos, n_best_pos;
    logic [KEY_W-1:0]      r_okey, n_okey;
    logic [TAG_W-1:0]      r_otag, n_otag;
    logic [STATUS_W-1:0]   r_ostatus, n_ostatus;

    logic                  r_out_valid, n_out_valid;
    logic [KEY_W-1:0]      r_out_key;
    logic [TAG_W-1:0]      r_out_tag;
    logic [STATUS_W-1:0]   r_out_status;
    logic [CNT_W-1:0]      r_out_occ;

    logic                  ram_we, ram_re;
    logic [IDX_W-1:0]      ram_waddr, ram_raddr;
    t_entry                ram_wdata, ram_rdata;

    logic                  w_accept, w_full, w_empty, w_out_load;
    logic [IDX_W-1:0]      w_pos_m1;
    logic [PROD_W-1:0]     w_prod;
    logic [CH_W-1:0]       w_first, w_next_child;
    logic                  w_leaf, w_cmp_last, w_take, w_up_swap, w_dn_swap;

    fahq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (HEAP_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_stall   = (r_state != S_IDLE);
    assign w_accept     = i_in_valid && !o_in_stall;
    assign w_full       = (r_count == FULL_CNT);
    assign w_empty      = (r_count == '0);
    assign w_out_load   = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    assign w_pos_m1     = r_pos - IDX_W'(1);
    assign w_prod       = PROD_W'(w_pos_m1) * PROD_W'(DIV_M);
    assign w_first      = CH_W'(r_pos) * CH_W'(ARITY) + CH_W'(1);
    assign w_leaf       = (w_first >= CH_W'(r_count));
    assign w_next_child = r_child + CH_W'(1);
    assign w_cmp_last   = (r_j == LAST_J) || (w_next_child >= CH_W'(r_count));
    assign w_take       = (r_j == '0) || (key_of(ram_rdata) < key_of(r_best));
    assign w_up_swap    = (key_of(r_move) < key_of(ram_rdata));
    assign w_dn_swap    = (key_of(r_move) > key_of(r_best));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_mode == MODE_PUSH) begin
                        n_state = w_full ? S_DONE : S_UP_PAR;
                    end else begin
                        n_state = w_empty ? S_DONE : S_POP_ROOT;
                    end
                end
            end
            S_UP_PAR: begin
                n_state = (r_pos == '0) ? S_DONE : S_UP_RD;
            end
            S_UP_RD: begin
                n_state = S_UP_CMP;
            end
            S_UP_CMP: begin
                n_state = w_up_swap ? S_UP_PAR : S_DONE;
            end
            S_POP_ROOT: begin
                n_state = S_POP_LAST;
            end
            S_POP_LAST: begin
                n_state = (r_count == '0) ? S_DONE : S_DN_CHILD;
            end
            S_DN_CHILD: begin
                n_state = w_leaf ? S_DONE : S_DN_CMP;
            end
            S_DN_CMP: begin
                n_state = w_cmp_last ? S_DN_DEC : S_DN_CMP;
            end
            S_DN_DEC: begin
                n_state = w_dn_swap ? S_DN_CHILD : S_DONE;
            end
            S_DONE: begin
                n_state = w_out_load ? S_IDLE : S_DONE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_count    = r_count;
        n_pos      = r_pos;
        n_parent   = r_parent;
        n_child    = r_child;
        n_j        = r_j;
        n_move     = r_move;
        n_best     = r_best;
        n_best_pos = r_best_pos;
        n_okey     = r_okey;
        n_otag     = r_otag;
        n_ostatus  = r_ostatus;
        ram_we     = 1'b0;
        ram_waddr  = r_pos;
        ram_wdata  = r_move;
        ram_re     = 1'b0;
        ram_raddr  = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_okey    = '0;
                    n_otag    = '0;
                    n_ostatus = ST_DONE;
                    n_move    = {i_priority_key, i_entry_tag};
                    n_pos     = r_count[IDX_W-1:0];
                    if (i_mode == MODE_PUSH) begin
                        if (w_full) begin
                            n_ostatus = ST_FULL;
                        end else begin
                            n_count = r_count + CNT_W'(1);
                        end
                    end else begin
                        if (w_empty) begin
                            n_ostatus = ST_EMPTY;
                        end else begin
                            n_count = r_count - CNT_W'(1);
                            ram_re  = 1'b1;
                        end
                    end
                end
            end
            S_UP_PAR: begin
                if (r_pos == '0) begin
                    ram_we = 1'b1;
                end else begin
                    n_parent = w_prod[DIV_S +: IDX_W];
                end
            end
            S_UP_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_parent;
            end
            S_UP_CMP: begin
                ram_we = 1'b1;
                if (w_up_swap) begin
                    ram_wdata = ram_rdata;
                    n_pos     = r_parent;
                end
            end
            S_POP_ROOT: begin
                n_okey    = key_of(ram_rdata);
                n_otag    = ram_rdata[TAG_W-1:0];
                ram_re    = 1'b1;
                ram_raddr = r_count[IDX_W-1:0];
            end
            S_POP_LAST: begin
                n_move = ram_rdata;
                n_pos  = '0;
            end
            S_DN_CHILD: begin
                if (w_leaf) begin
                    ram_we = 1'b1;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = w_first[IDX_W-1:0];
                    n_child   = w_first;
                    n_j       = '0;
                end
            end
            S_DN_CMP: begin
                if (w_take) begin
                    n_best     = ram_rdata;
                    n_best_pos = r_child[IDX_W-1:0];
                end
                if (!w_cmp_last) begin
                    ram_re    = 1'b1;
                    ram_raddr = w_next_child[IDX_W-1:0];
                    n_child   = w_next_child;
                    n_j       = r_j + J_W'(1);
                end
            end
            S_DN_DEC: begin
                ram_we = 1'b1;
                if (w_dn_swap) begin
                    ram_wdata = r_best;
                    n_pos     = r_best_pos;
                end
            end
            S_DONE: begin
                n_okey = r_okey;
            end
            default: begin
                n_okey = r_okey;
            end
        endcase
    end

    assign n_out_valid = w_out_load || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos      <= n_pos;
        r_parent   <= n_parent;
        r_child    <= n_child;
        r_j        <= n_j;
        r_move     <= n_move;
        r_best     <= n_best;
        r_best_pos <= n_best_pos;
        r_okey     <= n_okey;
        r_otag     <= n_otag;
        r_ostatus  <= n_ostatus;
        if (w_out_load) begin
            r_out_key    <= r_okey;
            r_out_tag    <= r_otag;
            r_out_status <= r_ostatus;
            r_out_occ    <= r_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_key   = r_out_key;
    assign o_out_tag   = r_out_tag;
    assign o_status    = r_out_status;
    assign o_occupancy = r_out_occ;

endmodule

/* src/fahq_checker.sv */
// ============================================================================
// fahq_port_checker
// Port-level checks of the heap queue, bound to the top level.
// ============================================================================
module fahq_port_checker #(
    parameter int HEAP_DEPTH = fahq_pkg::DEF_HEAP_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              o_in_stall,
    input  logic                              o_out_valid,
    input  logic                              i_out_stall,
    input  logic [fahq_pkg::KEY_W-1:0]        o_out_key,
    input  logic [fahq_pkg::TAG_W-1:0]        o_out_tag,
    input  logic [fahq_pkg::STATUS_W-1:0]     o_status,
    input  logic [$clog2(HEAP_DEPTH+1)-1:0]   o_occupancy
);

    import fahq_pkg::*;

    localparam int CNT_W = $clog2(HEAP_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(HEAP_DEPTH);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while an operation is in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_key)
            && $stable(o_out_tag) && $stable(o_status) && $stable(o_occupancy)))
        else $error("stalled output word changed");

    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_occupancy <= FULL_CNT))
        else $error("occupancy beyond heap depth");

    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_EMPTY) |->
            (o_occupancy == '0 && o_out_key == '0 && o_out_tag == '0))
        else $error("empty status with nonzero word");

    a_full_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_FULL) |->
            (o_occupancy == FULL_CNT && o_out_key == '0 && o_out_tag == '0))
        else $error("full status while heap not full");

endmodule

bind four_ary_min_heap_queue fahq_port_checker #(
    .HEAP_DEPTH (HEAP_DEPTH)
) u_fahq_port_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_key   (o_out_key),
    .o_out_tag   (o_out_tag),
    .o_status    (o_status),
    .o_occupancy (o_occupancy)
);
